@@ design/salc_pkg.sv @@
// Shared types, constants and codes of the set-associative LRU cache model.
`default_nettype none

package salc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_SET_BITS = 8;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_WIDTH   = 64;
    localparam int DEF_COUNT_WIDTH  = 32;

    // Fixed field widths
    localparam int REQ_W       = 2;
    localparam int TOTAL_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SET_BITS_W  = 4;
    localparam int WAYS_W      = 4;
    localparam int BLK_BITS_W  = 6;
    localparam int OUT_FLAGS_W = 4;
    localparam int OUT_TDATA_W = ((OUT_FLAGS_W + 3 * TOTAL_W + 7) / 8) * 8;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clear;   // write an empty row, advance the sweep
        logic accept;  // latch the request, read its set row
        logic update;  // write the reordered row back, load the result
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ design/salc_ctrl.sv @@
// Control state machine: clear sweep, request accept, lookup and result handoff.
`default_nettype none

module salc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire logic              i_m_ready,
    output logic                   o_m_valid,
    output salc_pkg::t_dp_cmd      o_cmd,
    input  wire salc_pkg::t_dp_sts i_sts
);
    import salc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // hold the row until the output register can take the word
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_s_ready    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            ST_LOOKUP: begin
                o_cmd.update = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

@@ design/salc_dp.sv @@
// Datapath: configuration, set row memory, tag compare, LRU reorder and totals.
`default_nettype none

module salc_dp #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH,
    parameter int COUNT_WIDTH  = salc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire salc_pkg::t_dp_cmd                 i_cmd,
    output salc_pkg::t_dp_sts                      o_sts,
    input  wire logic [salc_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [ADDR_WIDTH-1:0]             i_address,
    output logic                                   o_hit,
    output logic                                   o_miss,
    output logic                                   o_evicted,
    output logic                                   o_modify_hit,
    output logic [salc_pkg::TOTAL_W-1:0]           o_hit_total,
    output logic [salc_pkg::TOTAL_W-1:0]           o_miss_total,
    output logic [salc_pkg::TOTAL_W-1:0]           o_eviction_total
);
    import salc_pkg::*;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (ADDR_WIDTH + 1);
    localparam int SH_W     = 7;

    // configuration
    logic [SET_BITS_W-1:0] r_set_bits;
    logic [WAYS_W-1:0]     r_ways;
    logic [BLK_BITS_W-1:0] r_block_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_ways       <= WAYS_W'(1);
            r_block_bits <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLK_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // address split
    logic [SET_BITS_W-1:0] sb_eff;
    logic [SH_W-1:0]       tag_shamt;
    logic [ADDR_WIDTH-1:0] addr_blk;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      in_set;
    logic [ADDR_WIDTH-1:0] in_tag;

    assign sb_eff    = (32'(r_set_bits) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS)
                                                         : r_set_bits;
    assign tag_shamt = SH_W'(sb_eff) + SH_W'(r_block_bits);
    assign addr_blk  = i_address >> r_block_bits;
    assign set_mask  = ~({SET_W{1'b1}} << sb_eff);
    assign in_set    = addr_blk[SET_W-1:0] & set_mask;
    // a shift of the full width or more leaves a zero tag
    assign in_tag    = i_address >> tag_shamt;

    logic [ADDR_WIDTH-1:0] r_tag;
    logic [SET_W-1:0]      r_set;
    logic [REQ_W-1:0]      r_kind;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag  <= in_tag;
            r_set  <= in_set;
            r_kind <= i_req_type;
        end
    end

    // set row memory: tags of all ways above their valid bits
    logic [ROW_W-1:0] r_mem [NUM_SETS];
    logic [ROW_W-1:0] r_rd_row;
    logic [SET_W-1:0] r_clr_idx;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [ROW_W-1:0] upd_row;

    assign mem_we    = i_cmd.clear || i_cmd.update;
    assign mem_waddr = i_cmd.clear ? r_clr_idx : r_set;
    assign mem_wdata = i_cmd.clear ? '0 : upd_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_row <= r_mem[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + SET_W'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_idx == SET_W'(NUM_SETS - 1));

    // lookup and LRU reorder
    logic [MAX_WAYS-1:0]                 rd_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tags;
    logic [MAX_WAYS-1:0]                 dn_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] dn_tags;
    logic [MAX_WAYS-1:0]                 new_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tags;
    logic [NW_W-1:0]                     nw;
    logic                                found;
    logic [WAY_W-1:0]                    s_idx;
    logic [WAY_W-1:0]                    start;
    logic                                stop_found;
    logic [WAY_W-1:0]                    p_idx;
    logic                                lk_hit;
    logic                                lk_evict;

    assign rd_valid = r_rd_row[MAX_WAYS-1:0];
    assign rd_tags  = r_rd_row[ROW_W-1:MAX_WAYS];
    assign dn_valid = rd_valid >> 1;
    assign dn_tags  = rd_tags >> ADDR_WIDTH;

    always_comb begin
        if (r_ways == '0) begin
            nw = NW_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end
    end

    always_comb begin
        found = 1'b0;
        s_idx = '0;
        // first way in use that is empty or holds the tag
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!found && (i < int'(nw)) && (!rd_valid[i] || rd_tags[i] == r_tag)) begin
                found = 1'b1;
                s_idx = WAY_W'(i);
            end
        end
        lk_hit   = found && rd_valid[s_idx];
        lk_evict = !found;
        start    = found ? s_idx : '0;

        // younger lines slide down until an empty line is passed
        stop_found = 1'b0;
        p_idx      = WAY_W'(int'(nw) - 1);
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!stop_found && (i > int'(start)) && (i < int'(nw)) && !rd_valid[i]) begin
                stop_found = 1'b1;
                p_idx      = WAY_W'(i - 1);
            end
        end

        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i == int'(p_idx)) begin
                new_tags[i]  = r_tag;
                new_valid[i] = 1'b1;
            end else if ((i >= int'(start)) && (i < int'(p_idx))) begin
                new_tags[i]  = dn_tags[i];
                new_valid[i] = dn_valid[i];
            end else begin
                new_tags[i]  = rd_tags[i];
                new_valid[i] = rd_valid[i];
            end
        end
    end

    assign upd_row = {new_tags, new_valid};

    // saturating totals
    logic                   is_modify;
    logic [1:0]             hit_inc;
    logic [COUNT_WIDTH:0]   hit_sum;
    logic [COUNT_WIDTH:0]   miss_sum;
    logic [COUNT_WIDTH:0]   evict_sum;
    logic [COUNT_WIDTH-1:0] r_hit_cnt;
    logic [COUNT_WIDTH-1:0] r_miss_cnt;
    logic [COUNT_WIDTH-1:0] r_evict_cnt;

    assign is_modify = (r_kind == REQ_MODIFY);
    assign hit_inc   = 2'(lk_hit) + 2'(is_modify);
    assign hit_sum   = {1'b0, r_hit_cnt} + (COUNT_WIDTH + 1)'(hit_inc);
    assign miss_sum  = {1'b0, r_miss_cnt} + (COUNT_WIDTH + 1)'(!lk_hit);
    assign evict_sum = {1'b0, r_evict_cnt} + (COUNT_WIDTH + 1)'(lk_evict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (i_cmd.update) begin
            r_hit_cnt   <= hit_sum[COUNT_WIDTH] ? '1 : hit_sum[COUNT_WIDTH-1:0];
            r_miss_cnt  <= miss_sum[COUNT_WIDTH] ? '1 : miss_sum[COUNT_WIDTH-1:0];
            r_evict_cnt <= evict_sum[COUNT_WIDTH] ? '1 : evict_sum[COUNT_WIDTH-1:0];
        end
    end

    // result word flags
    logic r_hit;
    logic r_evicted;
    logic r_modify_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hit        <= lk_hit;
            r_evicted    <= lk_evict;
            r_modify_hit <= is_modify;
        end
    end

    assign o_hit            = r_hit;
    assign o_miss           = !r_hit;
    assign o_evicted        = r_evicted;
    assign o_modify_hit     = r_modify_hit;
    assign o_hit_total      = TOTAL_W'(r_hit_cnt);
    assign o_miss_total     = TOTAL_W'(r_miss_cnt);
    assign o_eviction_total = TOTAL_W'(r_evict_cnt);

endmodule

`default_nettype wire

@@ design/set_assoc_lru_cache_sim_unit.sv @@
// Top level of the set-associative LRU cache model: stream ports and config port.
`default_nettype none

// Tag-only set-associative cache with true LRU replacement. Each input word is
// one access (load, store or modify) and produces one result word with hit,
// miss and eviction flags and the saturating running totals. An access first
// reads the whole set row from the row memory, then compares all ways,
// reorders the row and writes it back; it waits in the write-back step while
// the previous result word has not been taken. Accesses are handled one at a
// time: tready is high only while no access is in progress. After reset the
// block clears all 2**MAX_SET_BITS sets of the row memory (256 by default),
// one set per cycle, with tready low; configuration writes are taken throughout.
module set_assoc_lru_cache_sim_unit #(
    parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH,
    parameter int COUNT_WIDTH  = salc_pkg::DEF_COUNT_WIDTH,
    localparam int S_TDATA_W   = ((ADDR_WIDTH + 7) / 8) * 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // address
    input  wire logic [S_TDATA_W-1:0]             i_s_axis_tdata,
    // req_type
    input  wire logic [salc_pkg::REQ_W-1:0]       i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // hit, miss, evicted, modify_hit, hit_total, miss_total, eviction_total
    output logic [salc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import salc_pkg::*;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic               hit;
    logic               miss;
    logic               evicted;
    logic               modify_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] eviction_total;

    salc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_s_axis_tuser),
        .i_address        (i_s_axis_tdata[ADDR_WIDTH-1:0]),
        .o_hit            (hit),
        .o_miss           (miss),
        .o_evicted        (evicted),
        .o_modify_hit     (modify_hit),
        .o_hit_total      (hit_total),
        .o_miss_total     (miss_total),
        .o_eviction_total (eviction_total)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({eviction_total, miss_total, hit_total,
                                          modify_hit, evicted, miss, hit});

endmodule

`default_nettype wire

@@ sim/set_assoc_lru_cache_sim_checker.sv @@
// Result checker for the LRU cache model: tracks tag state and compares every result word.
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_s_axis_tvalid,
    input  wire logic                               i_s_axis_tready,
    // address
    input  wire logic [63:0]                        i_s_axis_tdata,
    // req_type
    input  wire logic [salc_pkg::REQ_W-1:0]         i_s_axis_tuser,
    input  wire logic                               i_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // hit, miss, evicted, modify_hit, hit_total, miss_total, eviction_total
    input  wire logic [salc_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    import salc_pkg::*;

    localparam int NUM_SETS = 1 << DEF_MAX_SET_BITS;
    localparam int NUM_WAYS = DEF_MAX_WAYS;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // hit sits in bit 0 of the result word, so it is declared last
    typedef struct packed {
        logic [TOTAL_W-1:0] eviction_total;
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] hit_total;
        logic               modify_hit;
        logic               evicted;
        logic               miss;
        logic               hit;
    } t_lookup_result;

    logic [63:0]            line_tag [NUM_SETS][NUM_WAYS];
    logic                   line_vld [NUM_SETS][NUM_WAYS];
    logic [TOTAL_W-1:0]     hits, misses, evictions;
    logic [SET_BITS_W-1:0]  set_bits_reg;
    logic [WAYS_W-1:0]      ways_reg;
    logic [BLK_BITS_W-1:0]  block_bits_reg;
    t_lookup_result         results_due [$];
    int                     fails = 0;

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

    // Look up one access, reorder its set in LRU order and update the totals.
    function automatic t_lookup_result lookup(input logic [REQ_W-1:0] kind,
                                              input logic [63:0] addr);
        t_lookup_result r;
        int unsigned    sbe, nw, sh, set, w;
        logic [63:0]    tag;
        logic           found, evict;
        sbe = (set_bits_reg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_bits_reg;
        nw = (ways_reg == 0) ? 1 : ((ways_reg > NUM_WAYS) ? NUM_WAYS : ways_reg);
        sh = sbe + block_bits_reg;
        tag = (sh >= 64) ? 64'd0 : (addr >> sh);
        set = int'((addr >> block_bits_reg) & ((64'd1 << sbe) - 64'd1));
        found = 1'b0;
        evict = 1'b0;
        for (w = 0; w < nw; w++) begin
            if (!line_vld[set][w])
                break;
            if (line_tag[set][w] == tag) begin
                found = 1'b1;
                break;
            end
        end
        if (w == nw) begin
            evict = 1'b1;
            w = 0;
        end
        // shift younger lines down, stop once an empty line has moved
        while (w + 1 < nw) begin
            line_tag[set][w] = line_tag[set][w + 1];
            line_vld[set][w] = line_vld[set][w + 1];
            if (!line_vld[set][w])
                break;
            w++;
        end
        line_tag[set][w] = tag;
        line_vld[set][w] = 1'b1;

        if (found)
            hits = bump(hits);
        else
            misses = bump(misses);
        if (evict)
            evictions = bump(evictions);
        if (kind == REQ_MODIFY)
            hits = bump(hits);

        r.hit            = found;
        r.miss           = !found;
        r.evicted        = evict;
        r.modify_hit     = (kind == REQ_MODIFY);
        r.hit_total      = hits;
        r.miss_total     = misses;
        r.eviction_total = evictions;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want, got;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < NUM_WAYS; w++)
                    line_vld[s][w] = 1'b0;
            hits = '0;
            misses = '0;
            evictions = '0;
            set_bits_reg = '0;
            ways_reg = 4'd1;
            block_bits_reg = '0;
            results_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SET_BITS:   set_bits_reg = i_cfg_data[SET_BITS_W-1:0];
                    CFG_WAYS:       ways_reg = i_cfg_data[WAYS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_reg = i_cfg_data[BLK_BITS_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_lookup_result'(i_m_axis_tdata[$bits(t_lookup_result)-1:0]);
                if (results_due.size() == 0) begin
                    $error("result word arrived with no access outstanding");
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("miss", want.miss, got.miss);
                    check_field("evicted", want.evicted, got.evicted);
                    check_field("modify_hit", want.modify_hit, got.modify_hit);
                    check_field("hit_total", want.hit_total, got.hit_total);
                    check_field("miss_total", want.miss_total, got.miss_total);
                    check_field("eviction_total", want.eviction_total, got.eviction_total);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                results_due.push_back(lookup(i_s_axis_tuser, i_s_axis_tdata));
        end
        o_fail_count <= fails;
        o_pending <= results_due.size();
    end

endmodule

@@ sim/set_assoc_lru_cache_sim_unit_test.sv @@
// Testbench top for the LRU cache model: drives accesses and register writes, gives the verdict.
`timescale 1ns / 100ps

module set_assoc_lru_cache_sim_unit_test;
    import salc_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int WORDS_PER_PHASE = 170;
    localparam logic [REQ_W-1:0]     REQ_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [63:0]            s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending;
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          cur_set_bits = 0;
    int          cur_ways = 1;
    int          cur_block_bits = 0;
    logic [63:0] tag_base = '0;
    int          accesses = 0;
    int          geometries = 1;
    int          cycles = 0;

    set_assoc_lru_cache_sim_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    set_assoc_lru_cache_sim_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_access(input logic [REQ_W-1:0] kind, input logic [63:0] addr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= addr;
        do @(posedge clk); while (!s_tready);
        accesses++;
    endtask

    // Hold the input side until every outstanding result word is out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
    endtask

    task automatic set_geometry(input int sb, input int w, input int bb);
        drain();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS, w);
        write_reg(CFG_BLOCK_BITS, bb);
        cfg_wr_en <= 1'b0;
        cur_set_bits = sb;
        cur_ways = w;
        cur_block_bits = bb;
        tag_base = {$urandom, $urandom};
        geometries++;
    endtask

    // Mostly a few tags over a few hot sets so lines get reused and evicted.
    function automatic logic [63:0] pick_address();
        int unsigned sbe, nw, sh;
        logic [63:0] set_idx, offset, tag;
        sbe = (cur_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : cur_set_bits;
        nw = (cur_ways == 0) ? 1 : ((cur_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : cur_ways);
        sh = sbe + cur_block_bits;
        offset = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return offset;
        set_idx = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(3));
        set_idx &= (64'd1 << sbe) - 64'd1;
        tag = tag_base + 64'($urandom_range(nw + 1));
        offset &= (64'd1 << cur_block_bits) - 64'd1;
        return ((sh >= 64) ? 64'd0 : (tag << sh)) | (set_idx << cur_block_bits) | offset;
    endfunction

    task automatic run_phase(input int sb, input int w, input int bb);
        set_geometry(sb, w, bb);
        for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == WORDS_PER_PHASE / 2)
                drain();
            send_access(REQ_W'($urandom_range(3)), pick_address());
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 23;
        dst_idle_pct = 49;

        // reset geometry: one set, one way, no offset
        send_access(REQ_LOAD, 64'd0);
        send_access(REQ_LOAD, 64'd0);
        send_access(REQ_MODIFY, 64'd0);
        send_access(REQ_STORE, '1);
        send_access(REQ_SPARE, '1);

        // four ways in set 1: fill, evict, reuse from the middle
        set_geometry(2, 4, 4);
        for (int t = 1; t <= 5; t++)
            send_access(REQ_LOAD, (64'(t) << 6) | (64'd1 << 4));
        send_access(REQ_LOAD, (64'd3 << 6) | (64'd1 << 4));
        send_access(REQ_LOAD, (64'd1 << 6) | (64'd1 << 4));
        send_access(REQ_MODIFY, (64'd3 << 6) | (64'd1 << 4));
        send_access(REQ_LOAD, (64'd5 << 6) | (64'd1 << 4) | 64'hf);

        // oversized set and way counts, offset wide enough to leave no tag
        set_geometry(15, 15, 63);
        send_access(REQ_LOAD, 64'h8000_0000_0000_0000);
        send_access(REQ_LOAD, 64'd0);
        send_access(REQ_STORE, 64'h7fff_ffff_ffff_ffff);

        // zero ways acts as one
        set_geometry(0, 0, 32);
        send_access(REQ_LOAD, 64'hffff_ffff_0000_0000);
        send_access(REQ_LOAD, 64'hffff_ffff_1234_5678);
        send_access(REQ_MODIFY, 64'h0000_0001_0000_0000);

        // unused register index must change nothing
        drain();
        write_reg(CFG_SPARE, '1);
        cfg_wr_en <= 1'b0;
        send_access(REQ_LOAD, 64'h0000_0001_0000_0000);

        run_phase(2, 4, 4);
        run_phase(8, 8, 6);
        run_phase(0, 1, 0);

        src_idle_pct = 49;
        dst_idle_pct = 23;
        run_phase(15, 15, 32);
        run_phase(3, 0, 63);
        run_phase(1, 2, 5);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        run_phase(4, 3, 2);
        run_phase(8, 8, 32);
        run_phase(5, 9, 0);

        drain();
        $display("Covered %0d accesses over %0d cache geometries, including reuse, eviction,",
                 accesses, geometries);
        $display("modify, the spare request kind and out-of-range register values.");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ set_assoc_lru_cache_sim_unit.f @@
design/salc_pkg.sv
design/salc_ctrl.sv
design/salc_dp.sv
design/set_assoc_lru_cache_sim_unit.sv
sim/set_assoc_lru_cache_sim_checker.sv
sim/set_assoc_lru_cache_sim_unit_test.sv
